@@ hdl/nht_pkg.sv @@
`default_nettype none
package nht_pkg;
    localparam int TABLE_SLOTS = 128;
    localparam int NAME_STORE_BYTES = 64;
    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int POS_W = $clog2(NAME_STORE_BYTES);
    localparam int LEN_W = $clog2(NAME_STORE_BYTES + 1);
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam int PROBE_W = $clog2(TABLE_SLOTS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam logic [63:0] HASH_BASIS = 64'd1469598103934665603;
    localparam logic [63:0] HASH_PRIME = 64'd1099511628211;

    localparam logic [2:0] ST_ADDED = 3'd0;
    localparam logic [2:0] ST_UPDATED = 3'd1;
    localparam logic [2:0] ST_FOUND = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;
    localparam logic [2:0] ST_BAD_NAME = 3'd5;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic [7:0] name_char;
        logic       last_char;
        logic       operation;
        logic [15:0] new_msg_id;
    } name_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] found_msg_id;
        logic [7:0]  entry_count;
    } lookup_result_t;

    // one finished name: command for the back end
    typedef struct packed {
        logic              operation;
        logic              bad_name;
        logic [LEN_W-1:0]  key_length;
        logic [SLOT_W-1:0] home_slot;
        logic [15:0]       new_msg_id;
    } nht_cmd_t;

    // key byte read port from back end into front end
    typedef struct packed {
        logic [POS_W-1:0] addr;
    } nht_key_rd_t;
endpackage
`default_nettype wire

@@ hdl/nht_item_if.sv @@
`default_nettype none
interface nht_item_if;
    import nht_pkg::*;
    logic       valid;
    logic       ready;
    name_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ hdl/nht_result_if.sv @@
`default_nettype none
interface nht_result_if;
    import nht_pkg::*;
    logic           valid;
    logic           ready;
    lookup_result_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ hdl/name_hash_table_lookup_top.sv @@
`default_nettype none
// channel   dir  handshake     payload
// in_ch     in   valid/ready   name_char, last_char, operation, new_msg_id
// out_ch    out  valid/ready   status, found_msg_id, entry_count
// A nonzero byte is hashed (xor, then the 64-bit multiply); a zero byte is not.
// After the last byte the table walk reads each probed slot's length and
// compares keys bytewise; an add copies the name bytewise. Intake stalls
// while the walk still reads the key buffer; one command may wait in the queue.
// Reset loads the hash basis and clears key length, slot valid bits and count.
module name_hash_table_lookup_top (
    input wire logic clk,
    input wire logic rst_n,
    nht_item_if.sink     in_ch,
    nht_result_if.source out_ch
);
    import nht_pkg::*;

    logic        f_valid, f_ready, b_valid, b_ready, key_free;
    nht_cmd_t    f_cmd, b_cmd;
    nht_key_rd_t key_rd;
    logic [7:0]  key_rd_data;

    nht_front u_front (
        .clk, .rst_n, .in_ch,
        .cmd_valid(f_valid), .cmd(f_cmd), .cmd_ready(f_ready),
        .key_free, .key_rd, .key_rd_data
    );

    nht_queue u_queue (
        .clk, .rst_n,
        .push_valid(f_valid), .push_data(f_cmd), .push_ready(f_ready),
        .pop_valid(b_valid), .pop_data(b_cmd), .pop_ready(b_ready)
    );

    nht_back u_back (
        .clk, .rst_n,
        .cmd_valid(b_valid), .cmd(b_cmd), .cmd_ready(b_ready),
        .key_free, .key_rd, .key_rd_data, .out_ch
    );

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.payload.status <= ST_BAD_NAME)
        else $error("status out of range");
    a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.payload.status != ST_FOUND |-> out_ch.payload.found_msg_id == '0)
        else $error("id set without found");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.payload.entry_count <= 8'(TABLE_SLOTS))
        else $error("count above table size");
endmodule
`default_nettype wire

@@ hdl/nht_front.sv @@
`default_nettype none
module nht_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    nht_item_if.sink                  in_ch,
    output      logic                 cmd_valid,
    output      nht_pkg::nht_cmd_t    cmd,
    input  wire logic                 cmd_ready,
    input  wire logic                 key_free,
    input  wire nht_pkg::nht_key_rd_t key_rd,
    output      logic [7:0]           key_rd_data
);
    import nht_pkg::*;

    typedef enum logic [1:0] {S_BYTE, S_MUL, S_FOLD, S_WAIT} state_t;

    state_t           state_reg;
    logic [63:0]      hash_reg;
    logic [63:0]      xored_reg;
    logic [LEN_W-1:0] len_reg;
    logic             over_reg;
    logic             last_reg;
    logic             op_reg;
    logic [15:0]      id_reg;
    logic [7:0]       key_mem [NAME_STORE_BYTES];
    logic [7:0]       key_q_reg;
    logic [31:0]      fold;
    logic [63:0]      prod;

    // prime is 2^40 + 2^8 + low byte: two shifts and a narrow product
    assign prod = {xored_reg[23:0], 40'd0} + {xored_reg[55:0], 8'd0}
                  + (xored_reg * HASH_PRIME[7:0]);
    assign fold = hash_reg[31:0] ^ hash_reg[63:32];

    // hold intake until back end has released the key buffer
    assign in_ch.ready = (state_reg == S_BYTE) && key_free;
    assign cmd_valid = (state_reg == S_WAIT);
    assign cmd.operation = op_reg;
    assign cmd.bad_name = (len_reg == '0) || over_reg;
    assign cmd.key_length = len_reg;
    assign cmd.home_slot = fold[SLOT_W-1:0];
    assign cmd.new_msg_id = id_reg;
    assign key_rd_data = key_q_reg;

    always_ff @(posedge clk)
    begin
        key_q_reg <= key_mem[key_rd.addr];
        if (in_ch.valid && in_ch.ready && in_ch.payload.name_char != 8'd0
            && len_reg < LEN_W'(NAME_STORE_BYTES))
        begin
            key_mem[len_reg[POS_W-1:0]] <= in_ch.payload.name_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BYTE;
            hash_reg <= HASH_BASIS;
            len_reg <= '0;
            over_reg <= 1'b0;
            last_reg <= 1'b0;
            op_reg <= OP_ADD;
            id_reg <= '0;
            xored_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_BYTE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        last_reg <= in_ch.payload.last_char;
                        op_reg <= in_ch.payload.operation;
                        id_reg <= in_ch.payload.new_msg_id;
                        if (in_ch.payload.name_char != 8'd0)
                        begin
                            xored_reg <= hash_reg ^ {56'd0, in_ch.payload.name_char};
                            if (len_reg < LEN_W'(NAME_STORE_BYTES))
                                len_reg <= len_reg + 1'b1;
                            else
                                over_reg <= 1'b1;
                            state_reg <= S_MUL;
                        end
                        else if (in_ch.payload.last_char)
                        begin
                            state_reg <= S_WAIT;
                        end
                    end
                end
                S_MUL:
                begin
                    hash_reg <= prod;
                    state_reg <= last_reg ? S_WAIT : S_BYTE;
                end
                S_WAIT:
                begin
                    if (cmd_ready)
                    begin
                        hash_reg <= HASH_BASIS;
                        len_reg <= '0;
                        over_reg <= 1'b0;
                        state_reg <= S_BYTE;
                    end
                end
                default: state_reg <= S_BYTE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ hdl/nht_queue.sv @@
`default_nettype none
module nht_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    input  wire nht_pkg::nht_cmd_t push_data,
    output      logic              push_ready,
    output      logic              pop_valid,
    output      nht_pkg::nht_cmd_t pop_data,
    input  wire logic              pop_ready
);
    import nht_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    nht_cmd_t           mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_reg;
    logic [PTR_W-1:0]   rd_reg;
    logic [PTR_W:0]     cnt_reg;
    logic               push;
    logic               pop;

    assign push_ready = cnt_reg < (PTR_W+1)'(QUEUE_DEPTH);
    assign pop_valid = cnt_reg != '0;
    assign pop_data = mem_reg[rd_reg];
    assign push = push_valid && push_ready;
    assign pop = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
        end
    end
endmodule
`default_nettype wire

@@ hdl/nht_back.sv @@
`default_nettype none
module nht_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cmd_valid,
    input  wire nht_pkg::nht_cmd_t     cmd,
    output      logic                  cmd_ready,
    output      logic                  key_free,
    output      nht_pkg::nht_key_rd_t  key_rd,
    input  wire logic [7:0]            key_rd_data,
    nht_result_if.source               out_ch
);
    import nht_pkg::*;

    localparam int BYTE_ADDR_W = SLOT_W + POS_W;

    typedef enum logic [3:0] {
        B_IDLE, B_SLOT, B_SLOTW, B_CMP, B_CMPW, B_COPY, B_COPYW, B_DONE
    } state_t;

    state_t              state_reg;
    nht_cmd_t            cmd_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [PROBE_W-1:0]  probes_reg;
    logic [LEN_W-1:0]    pos_reg;
    logic [TABLE_SLOTS-1:0] used_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [LEN_W-1:0]    len_mem [TABLE_SLOTS];
    logic [15:0]         id_mem [TABLE_SLOTS];
    logic [7:0]          byte_mem [TABLE_SLOTS * NAME_STORE_BYTES];
    logic [LEN_W-1:0]    len_q_reg;
    logic [15:0]         id_q_reg;
    logic [7:0]          byte_q_reg;
    logic                len_we;
    logic                id_we;
    logic                byte_we;
    logic                res_valid_reg;
    lookup_result_t      res_reg;
    logic                key_busy_reg;
    logic [POS_W-1:0]    pos_idx;
    logic [BYTE_ADDR_W-1:0] byte_addr;

    assign pos_idx = pos_reg[POS_W-1:0];
    assign byte_addr = {slot_reg, pos_idx};
    assign key_rd.addr = pos_idx;
    assign cmd_ready = (state_reg == B_IDLE) && !res_valid_reg;
    assign key_free = !key_busy_reg && !(cmd_valid);
    assign out_ch.valid = res_valid_reg;
    assign out_ch.payload = res_reg;

    assign len_we = (state_reg == B_COPY) && (pos_reg == cmd_reg.key_length);
    assign id_we = len_we || ((state_reg == B_CMP) && (pos_reg == cmd_reg.key_length)
                   && (cmd_reg.operation == OP_ADD) && used_reg[slot_reg]);
    assign byte_we = (state_reg == B_COPYW);

    always_ff @(posedge clk)
    begin
        len_q_reg <= len_mem[slot_reg];
        id_q_reg <= id_mem[slot_reg];
        byte_q_reg <= byte_mem[byte_addr];
        if (len_we)
            len_mem[slot_reg] <= cmd_reg.key_length;
        if (id_we)
            id_mem[slot_reg] <= cmd_reg.new_msg_id;
        if (byte_we)
            byte_mem[{slot_reg, POS_W'(pos_reg - 1'b1)}] <= key_rd_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            cmd_reg <= '0;
            slot_reg <= '0;
            probes_reg <= '0;
            pos_reg <= '0;
            used_reg <= '0;
            count_reg <= '0;
            res_valid_reg <= 1'b0;
            res_reg <= '0;
            key_busy_reg <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && out_ch.ready)
                res_valid_reg <= 1'b0;
            case (state_reg)
                B_IDLE:
                begin
                    if (cmd_valid && cmd_ready)
                    begin
                        cmd_reg <= cmd;
                        slot_reg <= cmd.home_slot;
                        probes_reg <= '0;
                        pos_reg <= '0;
                        key_busy_reg <= 1'b1;
                        state_reg <= cmd.bad_name ? B_DONE : B_SLOT;
                        res_reg.status <= ST_BAD_NAME;
                        res_reg.found_msg_id <= '0;
                    end
                end
                B_SLOT:
                begin
                    pos_reg <= '0;
                    if (probes_reg == PROBE_W'(TABLE_SLOTS))
                    begin
                        res_reg.status <= (cmd_reg.operation == OP_ADD) ? ST_FULL
                                                                       : ST_NOT_FOUND;
                        state_reg <= B_DONE;
                    end
                    else if (!used_reg[slot_reg])
                    begin
                        if (cmd_reg.operation == OP_ADD)
                        begin
                            state_reg <= B_COPY;
                        end
                        else
                        begin
                            res_reg.status <= ST_NOT_FOUND;
                            state_reg <= B_DONE;
                        end
                    end
                    else
                    begin
                        state_reg <= B_SLOTW;
                    end
                end
                B_SLOTW:
                begin
                    if (len_q_reg != cmd_reg.key_length)
                    begin
                        slot_reg <= slot_reg + 1'b1;
                        probes_reg <= probes_reg + 1'b1;
                        state_reg <= B_SLOT;
                    end
                    else
                    begin
                        state_reg <= B_CMPW;
                    end
                end
                B_CMPW:
                begin
                    // wait here while the stored and key bytes at pos_reg are read out
                    state_reg <= B_CMP;
                end
                B_CMP:
                begin
                    if (pos_reg == cmd_reg.key_length)
                    begin
                        if (cmd_reg.operation == OP_ADD)
                        begin
                            res_reg.status <= ST_UPDATED;
                        end
                        else
                        begin
                            res_reg.status <= ST_FOUND;
                            res_reg.found_msg_id <= id_q_reg;
                        end
                        state_reg <= B_DONE;
                    end
                    else if (byte_q_reg != key_rd_data)
                    begin
                        slot_reg <= slot_reg + 1'b1;
                        probes_reg <= probes_reg + 1'b1;
                        state_reg <= B_SLOT;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + 1'b1;
                        state_reg <= B_CMPW;
                    end
                end
                B_COPY:
                begin
                    if (pos_reg == cmd_reg.key_length)
                    begin
                        used_reg[slot_reg] <= 1'b1;
                        count_reg <= count_reg + 1'b1;
                        res_reg.status <= ST_ADDED;
                        state_reg <= B_DONE;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + 1'b1;
                        state_reg <= B_COPYW;
                    end
                end
                B_COPYW:
                begin
                    state_reg <= B_COPY;
                end
                B_DONE:
                begin
                    if (!res_valid_reg)
                    begin
                        res_valid_reg <= 1'b1;
                        res_reg.entry_count <= 8'(count_reg);
                        key_busy_reg <= 1'b0;
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
